[sv/mmm_pkg.sv]
// ============================================================================
// mmm_pkg
// Shared constants for the multinomial coefficient unit: field widths, the
// configuration register map and the default bound.
// ============================================================================
package mmm_pkg;

  // Field widths fixed by the interface
  localparam int CountWidth   = 13;
  localparam int ModWidth     = 30;
  localparam int InDataWidth  = 16;
  localparam int OutDataWidth = 32;
  localparam int CfgDataWidth = 32;
  localparam int CfgAddrWidth = 3;

  // Default bound on counts and on their sum
  localparam int MaxValueDefault = 4096;

  // Reset value of the modulus register
  localparam logic [ModWidth-1:0] ModulusReset = 30'd1000000007;

  // Register index codes, taken from the word address bit
  localparam logic RegModulus = 1'b0;

endpackage

[sv/mmm_ram.sv]
// ============================================================================
// mmm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
module mmm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  logic [WIDTH-1:0]                wr_data,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr,
  output logic [WIDTH-1:0]                rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/multinomial_mod_m_unit.sv]
// ============================================================================
// multinomial_mod_m_unit
// Multinomial coefficient modulo a configurable modulus, built from prime
// exponents kept in a RAM and a small sequencer around one shared datapath.
// ============================================================================
// A run is a stream of counts; the transfer with tlast high ends it and
// returns one result, (c1+...+cn)! / (c1!*...*cn!) mod modulus, with tuser
// set and a zero result if the sum went above MAX_VALUE. After reset the unit
// clears its RAMs and then builds its prime table, and accepts nothing
// meanwhile. A count c walks the table up to c, with repeated subtraction
// for each prime p up to c. The last transfer then walks every table entry,
// with the subtraction steps for the sum, and multiplies the accumulator by
// each prime once per unit of that prime's exponent (one doubling per index
// bit and one addition per set bit of the prime); the modular multiplier is
// the bottleneck of this phase. A run that overflows, or a modulus of zero,
// ends instead with a clearing sweep of the exponent RAM. The input is ready
// only while the sequencer is idle; the result waits in an output register.
module multinomial_mod_m_unit #(
  parameter int MAX_VALUE = mmm_pkg::MaxValueDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream: tdata = count[12:0], zero padding; tlast = last
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mmm_pkg::InDataWidth-1:0]   in_tdata,
  input  logic                              in_tlast,
  // Result stream: tdata = result[29:0], zero padding; tuser = overflow
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mmm_pkg::OutDataWidth-1:0]  out_tdata,
  output logic                              out_tuser,
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mmm_pkg::CfgAddrWidth-1:0]  cfg_paddr,
  input  logic [mmm_pkg::CfgDataWidth-1:0]  cfg_pwdata,
  output logic [mmm_pkg::CfgDataWidth-1:0]  cfg_prdata,
  output logic                              cfg_pready
);

  localparam int Depth = MAX_VALUE + 1;
  localparam int AW    = $clog2(Depth);
  localparam int EW    = AW + 1;
  localparam int CW    = mmm_pkg::CountWidth;
  localparam int LW    = (AW > CW) ? AW : CW;
  localparam int PCW   = AW + 1;
  localparam int BW    = $clog2(AW);
  localparam int MW    = mmm_pkg::ModWidth;

  typedef enum logic [13:0] {
    ST_INIT    = 14'b00000000000001,
    ST_SV_RD   = 14'b00000000000010,
    ST_SV_CHK  = 14'b00000000000100,
    ST_SV_MARK = 14'b00000000001000,
    ST_IDLE    = 14'b00000000010000,
    ST_W_RD    = 14'b00000000100000,
    ST_W_CHK   = 14'b00000001000000,
    ST_W_DIV   = 14'b00000010000000,
    ST_W_UPD   = 14'b00000100000000,
    ST_M_DBL   = 14'b00001000000000,
    ST_M_ADD   = 14'b00010000000000,
    ST_FIN     = 14'b00100000000000,
    ST_CLR     = 14'b01000000000000,
    ST_DONE    = 14'b10000000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [PCW-1:0]  addr_r, addr_nxt;
  logic [AW:0]     j_r, j_nxt;
  logic            final_r, final_nxt;
  logic            last_r, last_nxt;
  logic [AW-1:0]   lim_r, lim_nxt;
  logic [AW-1:0]   sum_r, sum_nxt;
  logic            big_r, big_nxt;
  logic [MW-1:0]   modulus_r, modulus_nxt;
  logic [MW-1:0]   acc_r, acc_nxt;
  logic [MW-1:0]   t_r, t_nxt;
  logic [BW-1:0]   bit_r, bit_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   rem_r, rem_nxt;
  logic [AW-1:0]   quo_r, quo_nxt;
  logic [AW-1:0]   e_r, e_nxt;
  logic [EW-1:0]   stv_r, stv_nxt;
  logic [MW-1:0]   res_r, res_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [MW-1:0]   out_res_r, out_res_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  // RAM ports
  logic            comp_we, expo_we;
  logic [AW-1:0]   comp_waddr, expo_waddr, rd_addr;
  logic            comp_wdata, comp_rd;
  logic [EW-1:0]   expo_wdata, expo_rd;

  // Datapath helpers
  logic [LW-1:0]   c_ext;
  logic [LW:0]     sum_c;
  logic [AW-1:0]   p_cur;
  logic [PCW-1:0]  walk_lim;
  logic [AW+1:0]   i_dbl;
  logic [AW:0]     j_step;
  logic [AW-1:0]   e_sum;
  logic signed [EW:0] tot;
  logic [MW:0]     t_dbl, t_add;
  logic [MW-1:0]   t_dbl_red, t_add_red, t_step;
  logic            cfg_write;

  // Composite flags, built by the sieve after reset
  mmm_ram #(.WIDTH(1), .DEPTH(Depth)) u_comp_ram (
    .clk     (clk),
    .wr_en   (comp_we),
    .wr_addr (comp_waddr),
    .wr_data (comp_wdata),
    .rd_addr (rd_addr),
    .rd_data (comp_rd)
  );

  // Signed exponent per table entry, indexed by the value itself
  mmm_ram #(.WIDTH(EW), .DEPTH(Depth)) u_expo_ram (
    .clk     (clk),
    .wr_en   (expo_we),
    .wr_addr (expo_waddr),
    .wr_data (expo_wdata),
    .rd_addr (rd_addr),
    .rd_data (expo_rd)
  );

  // Configuration port: one register, writes beyond it are dropped
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == mmm_pkg::RegModulus) ?
                      {{(mmm_pkg::CfgDataWidth-MW){1'b0}}, modulus_r} :
                      '0;

  // Handshake and output payload
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mmm_pkg::OutDataWidth-MW){1'b0}}, out_res_r};
  assign out_tuser  = out_ovf_r;

  // Shared arithmetic: the sum check, the walk limit and one modular step
  always_comb begin
    c_ext     = LW'(in_tdata[CW-1:0]);
    sum_c     = (LW+1)'(sum_r) + (LW+1)'(c_ext);
    p_cur     = addr_r[AW-1:0];
    walk_lim  = final_r ? PCW'(MAX_VALUE) : PCW'(lim_r);
    i_dbl     = {addr_r, 1'b0};
    j_step    = j_r + (AW+1)'(addr_r);
    e_sum     = e_r + quo_r;
    tot       = $signed({stv_r[EW-1], stv_r}) + $signed({2'b00, e_r});
    t_dbl     = {t_r, 1'b0};
    t_dbl_red = (t_dbl >= {1'b0, modulus_r}) ? MW'(t_dbl - {1'b0, modulus_r}) :
                                                t_dbl[MW-1:0];
    t_add     = {1'b0, t_r} + {1'b0, acc_r};
    t_add_red = (t_add >= {1'b0, modulus_r}) ? MW'(t_add - {1'b0, modulus_r}) :
                                                t_add[MW-1:0];
    t_step    = (state_r == ST_M_ADD) ? t_add_red : t_dbl_red;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    j_nxt         = j_r;
    final_nxt     = final_r;
    last_nxt      = last_r;
    lim_nxt       = lim_r;
    sum_nxt       = sum_r;
    big_nxt       = big_r;
    modulus_nxt   = modulus_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    e_nxt         = e_r;
    stv_nxt       = stv_r;
    res_nxt       = res_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_ovf_nxt   = out_ovf_r;
    comp_we       = 1'b0;
    comp_waddr    = addr_r[AW-1:0];
    comp_wdata    = 1'b0;
    expo_we       = 1'b0;
    expo_waddr    = addr_r[AW-1:0];
    expo_wdata    = '0;
    rd_addr       = addr_r[AW-1:0];

    if (cfg_write && (cfg_paddr[2] == mmm_pkg::RegModulus)) begin
      modulus_nxt = cfg_pwdata[MW-1:0];
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Clear both RAMs once after reset
      ST_INIT: begin
        comp_we = 1'b1;
        expo_we = 1'b1;
        if (addr_r == PCW'(MAX_VALUE)) begin
          addr_nxt  = PCW'(2);
          state_nxt = ST_SV_RD;
        end else begin
          addr_nxt = addr_r + PCW'(1);
        end
      end

      // Sieve: look up the next candidate while twice it is in range
      ST_SV_RD: begin
        if (i_dbl > (AW+2)'(MAX_VALUE)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SV_CHK;
        end
      end

      ST_SV_CHK: begin
        if (!comp_rd) begin
          j_nxt     = i_dbl[AW:0];
          state_nxt = ST_SV_MARK;
        end else begin
          addr_nxt  = addr_r + PCW'(1);
          state_nxt = ST_SV_RD;
        end
      end

      // Mark every multiple of a prime, from twice it up to MAX_VALUE, as composite
      ST_SV_MARK: begin
        comp_we    = 1'b1;
        comp_waddr = j_r[AW-1:0];
        comp_wdata = 1'b1;
        if (j_step > (AW+1)'(MAX_VALUE)) begin
          addr_nxt  = addr_r + PCW'(1);
          state_nxt = ST_SV_RD;
        end else begin
          j_nxt = j_step;
        end
      end

      // Take one count and decide whether its exponents are walked
      ST_IDLE: begin
        if (in_tvalid) begin
          last_nxt  = in_tlast;
          state_nxt = in_tlast ? ST_FIN : ST_IDLE;
          if (!big_r) begin
            if (c_ext > LW'(MAX_VALUE) || sum_c > (LW+1)'(MAX_VALUE)) begin
              big_nxt = 1'b1;
            end else begin
              sum_nxt   = sum_c[AW-1:0];
              lim_nxt   = c_ext[AW-1:0];
              final_nxt = 1'b0;
              addr_nxt  = PCW'(2);
              state_nxt = ST_W_RD;
            end
          end
        end
      end

      // Walk over the table: stop past the limit
      ST_W_RD: begin
        if (addr_r > walk_lim) begin
          if (final_r) begin
            res_nxt   = acc_r;
            ovf_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = last_r ? ST_FIN : ST_IDLE;
          end
        end else begin
          state_nxt = ST_W_CHK;
        end
      end

      ST_W_CHK: begin
        stv_nxt = expo_rd;
        if (comp_rd) begin
          addr_nxt  = addr_r + PCW'(1);
          state_nxt = ST_W_RD;
        end else begin
          rem_nxt   = lim_r;
          quo_nxt   = '0;
          e_nxt     = '0;
          state_nxt = ST_W_DIV;
        end
      end

      // Legendre's formula by repeated subtraction of the prime
      ST_W_DIV: begin
        if (rem_r >= p_cur) begin
          rem_nxt = rem_r - p_cur;
          quo_nxt = quo_r + AW'(1);
        end else begin
          e_nxt = e_sum;
          if (quo_r >= p_cur) begin
            rem_nxt = quo_r;
            quo_nxt = '0;
          end else begin
            state_nxt = ST_W_UPD;
          end
        end
      end

      // Update the stored exponent, or use and clear it on the last count
      ST_W_UPD: begin
        expo_we = 1'b1;
        if (!final_r) begin
          expo_wdata = stv_r - EW'(e_r);
          addr_nxt   = addr_r + PCW'(1);
          state_nxt  = ST_W_RD;
        end else begin
          expo_wdata = '0;
          if (tot > 0) begin
            cnt_nxt   = tot[AW-1:0];
            bit_nxt   = BW'(AW - 1);
            t_nxt     = '0;
            state_nxt = ST_M_DBL;
          end else begin
            addr_nxt  = addr_r + PCW'(1);
            state_nxt = ST_W_RD;
          end
        end
      end

      // Multiply the accumulator by the prime, one bit of it at a time
      ST_M_DBL, ST_M_ADD: begin
        t_nxt = t_step;
        if (state_r == ST_M_DBL && p_cur[bit_r]) begin
          state_nxt = ST_M_ADD;
        end else if (bit_r != '0) begin
          bit_nxt   = bit_r - BW'(1);
          state_nxt = ST_M_DBL;
        end else begin
          acc_nxt = t_step;
          if (cnt_r == AW'(1)) begin
            addr_nxt  = addr_r + PCW'(1);
            state_nxt = ST_W_RD;
          end else begin
            cnt_nxt   = cnt_r - AW'(1);
            bit_nxt   = BW'(AW - 1);
            t_nxt     = '0;
            state_nxt = ST_M_DBL;
          end
        end
      end

      // Start the final pass, or give the zero answer and sweep the store
      ST_FIN: begin
        if (big_r || modulus_r == '0) begin
          res_nxt   = '0;
          ovf_nxt   = big_r;
          addr_nxt  = '0;
          state_nxt = ST_CLR;
        end else begin
          acc_nxt   = (modulus_r == MW'(1)) ? '0 : MW'(1);
          lim_nxt   = sum_r;
          final_nxt = 1'b1;
          addr_nxt  = PCW'(2);
          state_nxt = ST_W_RD;
        end
      end

      ST_CLR: begin
        expo_we = 1'b1;
        if (addr_r == PCW'(MAX_VALUE)) begin
          state_nxt = ST_DONE;
        end else begin
          addr_nxt = addr_r + PCW'(1);
        end
      end

      // Hand the answer to the output register and end the run
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_ovf_nxt   = ovf_r;
          sum_nxt       = '0;
          big_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      addr_r      <= '0;
      sum_r       <= '0;
      big_r       <= 1'b0;
      modulus_r   <= mmm_pkg::ModulusReset;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      sum_r       <= sum_nxt;
      big_r       <= big_nxt;
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
    end
    j_r       <= j_nxt;
    final_r   <= final_nxt;
    last_r    <= last_nxt;
    lim_r     <= lim_nxt;
    acc_r     <= acc_nxt;
    t_r       <= t_nxt;
    bit_r     <= bit_nxt;
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    e_r       <= e_nxt;
    stv_r     <= stv_nxt;
    res_r     <= res_nxt;
    ovf_r     <= ovf_nxt;
    out_res_r <= out_res_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

endmodule
